// ===== rtl/core/ellipse_span_switch_points_top_assert.svh =====
// assertion macros shared by the ellipse span modules
`ifndef ELLIPSE_SPAN_SWITCH_POINTS_TOP_ASSERT_SVH
`define ELLIPSE_SPAN_SWITCH_POINTS_TOP_ASSERT_SVH

// condition that holds at every edge out of reset
`define ESP_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("esp: invariant violated");

// same-cycle implication
`define ESP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("esp: implication violated");

// next-cycle implication
`define ESP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("esp: next-cycle implication violated");

`endif

// ===== rtl/core/esp_pkg.sv =====
// types, widths and constants of the ellipse span switch point walker
`timescale 1ns / 1ps
package esp_pkg;

    localparam int COORD_BITS = 16;
    localparam int AXIS_BITS  = 12;

    localparam int ID_W       = 16;
    localparam int HEIGHT_W   = 13;
    localparam int OUT_X_W    = 15;
    localparam int OUT_Y_W    = 12;
    localparam int LIM_MAX    = 4096;
    localparam int HEIGHT_RST = 480;
    localparam int X_MAX      = 32767;

    // walk and arithmetic widths
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int WX_W   = AXIS_BITS + 1;
    localparam int WALK_W = AXIS_BITS + 2;
    localparam int OPB_W  = AXIS_BITS + 4;
    localparam int PROD_W = SQ_W + 1 + OPB_W;
    localparam int DEC_W  = PROD_W + 3;

    // point coordinate widths
    localparam int PT_W = ((COORD_BITS > WALK_W) ? COORD_BITS : WALK_W) + 1;
    localparam int XC_W = ((PT_W > OUT_X_W + 1) ? PT_W : OUT_X_W + 1) + 1;
    localparam int YC_W = (PT_W > HEIGHT_W) ? PT_W : HEIGHT_W;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;
    localparam logic LEVEL_ON  = 1'b1;
    localparam logic LEVEL_OFF = 1'b0;

    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] centre_x;
        logic signed [COORD_BITS-1:0] centre_y;
        logic [AXIS_BITS-1:0]         semi_x;
        logic [AXIS_BITS-1:0]         semi_y;
        logic                         solid;
        logic [ID_W-1:0]              shape_id;
    } t_in_item;

    typedef struct packed {
        logic               point_valid;
        logic [OUT_X_W-1:0] point_x;
        logic [OUT_Y_W-1:0] point_y;
        logic [ID_W-1:0]    point_id;
        logic               point_on;
        logic               last_of_step;
        logic               shape_done;
    } t_out_item;

    typedef enum logic [1:0] {
        EK_NONE,
        EK_PAIR,
        EK_FOUR
    } t_emit_kind;

    typedef struct packed {
        t_emit_kind                   kind;
        logic                         done;
        logic [WX_W-1:0]              x_off;
        logic signed [WALK_W-1:0]     y_off;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic                         solid;
        logic [ID_W-1:0]              id;
    } t_emit_cmd;

    typedef struct packed {
        logic [SQ_W-1:0]         a;
        logic signed [OPB_W-1:0] b;
    } t_mul_op;

endpackage

// ===== rtl/core/esp_mul.sv =====
// shared multiplier with registered product
`timescale 1ns / 1ps
module esp_mul (
    input  logic                              i_clk,
    input  esp_pkg::t_mul_op                  i_op,
    output logic signed [esp_pkg::PROD_W-1:0] o_prod
);
    import esp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, i_op.a}) * i_op.b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/esp_emit.sv =====
// point former, screen clip and output register
`timescale 1ns / 1ps
`include "ellipse_span_switch_points_top_assert.svh"
module esp_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [esp_pkg::HEIGHT_W-1:0]   i_lim,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  esp_pkg::t_emit_cmd             i_cmd,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output esp_pkg::t_out_item             o_res
);
    import esp_pkg::*;

    localparam logic signed [XC_W-1:0] XSAT = XC_W'(X_MAX);

    logic signed [PT_W-1:0] cx_w, cy_w, xo_w, yo_w;
    logic signed [PT_W-1:0] yp, ym, xp, xm;
    logic [3:0]             mask_new;

    logic                   r_busy, r_empty, r_solid, r_done;
    logic [3:0]             r_mask;
    logic signed [PT_W-1:0] r_xp, r_xm, r_yp, r_ym;
    logic [ID_W-1:0]        r_id;
    logic                   r_res_valid;
    t_out_item              r_res;
    t_out_item              n_res;

    logic                   slot_free;
    logic [1:0]             idx;
    logic [3:0]             rem;
    logic signed [PT_W-1:0] sel_x, sel_y;
    logic signed [XC_W-1:0] xc;
    logic [OUT_X_W-1:0]     px;
    logic                   on_lvl;

    function automatic logic y_ok(input logic signed [PT_W-1:0] y, input logic [HEIGHT_W-1:0] l);
        logic [YC_W-1:0] yu;
        logic [YC_W-1:0] lu;
        yu = YC_W'($unsigned(y));
        lu = YC_W'(l);
        return !y[PT_W-1] && (yu < lu);
    endfunction

    // candidate rows and columns for the new request
    always_comb begin
        cx_w = PT_W'(i_cmd.cx);
        cy_w = PT_W'(i_cmd.cy);
        xo_w = PT_W'(i_cmd.x_off);
        yo_w = PT_W'(i_cmd.y_off);
        yp   = cy_w + yo_w;
        ym   = cy_w - yo_w;
        xp   = cx_w + xo_w;
        xm   = cx_w - xo_w;
        unique case (i_cmd.kind)
            EK_FOUR: mask_new = {y_ok(ym, i_lim), y_ok(ym, i_lim),
                                 y_ok(yp, i_lim), y_ok(yp, i_lim)};
            EK_PAIR: mask_new = {2'b00, y_ok(yp, i_lim), y_ok(yp, i_lim)};
            default: mask_new = 4'b0000;
        endcase
    end

    assign o_cmd_ready = !r_busy;
    assign slot_free   = !r_res_valid || i_res_ready;

    // lowest pending candidate goes first
    always_comb begin
        if (r_mask[0]) begin
            idx = 2'd0;
        end else if (r_mask[1]) begin
            idx = 2'd1;
        end else if (r_mask[2]) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
        rem    = r_mask & ~(4'b0001 << idx);
        sel_x  = idx[0] ? r_xp : r_xm;
        sel_y  = idx[1] ? r_ym : r_yp;
        on_lvl = (idx[0] ^ r_solid) ? LEVEL_ON : LEVEL_OFF;
        xc     = XC_W'(sel_x);
        if (xc[XC_W-1]) begin
            px = '0;
        end else if (xc > XSAT) begin
            px = OUT_X_W'(X_MAX);
        end else begin
            px = xc[OUT_X_W-1:0];
        end
    end

    // next result: an empty marker or the selected point
    always_comb begin
        n_res              = '0;
        n_res.last_of_step = 1'b1;
        n_res.shape_done   = r_done;
        if (!r_empty) begin
            n_res.point_valid  = 1'b1;
            n_res.point_x      = px;
            n_res.point_y      = sel_y[OUT_Y_W-1:0];
            n_res.point_id     = r_id;
            n_res.point_on     = on_lvl;
            n_res.last_of_step = (rem == 4'b0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_empty     <= 1'b0;
            r_mask      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (!r_busy) begin
                if (i_res_ready) begin
                    r_res_valid <= 1'b0;
                end
                if (i_cmd_valid) begin
                    r_busy  <= 1'b1;
                    r_mask  <= mask_new;
                    r_empty <= (mask_new == 4'b0000);
                    r_xp    <= xp;
                    r_xm    <= xm;
                    r_yp    <= yp;
                    r_ym    <= ym;
                    r_id    <= i_cmd.id;
                    r_solid <= i_cmd.solid;
                    r_done  <= i_cmd.done;
                end
            end else if (slot_free) begin
                r_res_valid <= 1'b1;
                r_res       <= n_res;
                if (r_empty) begin
                    r_busy <= 1'b0;
                end else begin
                    r_mask <= rem;
                    r_busy <= (rem != 4'b0000);
                end
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `ESP_ASSERT_IMPL(a_point_not_done, (r_res_valid && r_res.point_valid), !r_res.shape_done)
    `ESP_ASSERT_IMPL(a_idle_no_pending, !r_busy, (r_mask == 4'b0000))
    `ESP_ASSERT_NEXT(a_point_loaded, (r_busy && slot_free && !r_empty),
                     (o_res_valid && o_res.point_valid))

endmodule

// ===== rtl/core/esp_seq.sv =====
// walk sequencer: drives the shared multiplier and keeps the walk state
`timescale 1ns / 1ps
`include "ellipse_span_switch_points_top_assert.svh"
module esp_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  esp_pkg::t_in_item                 i_req,
    output esp_pkg::t_mul_op                  o_mul_op,
    input  logic signed [esp_pkg::PROD_W-1:0] i_prod,
    output logic                              o_cmd_valid,
    input  logic                              i_cmd_ready,
    output esp_pkg::t_emit_cmd                o_cmd
);
    import esp_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TOPBOT,
        PH_SIDES
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_SQA, S_SQB, S_DEC0, S_DEC1,
        S_T1, S_T2, S_TCMP, S_TUPA, S_TACCA, S_TUPB, S_TACCB, S_SET, S_SET2,
        S_S1, S_S2, S_SCMP, S_SUPC, S_SACCC, S_SUPD, S_SACCD,
        S_EMIT
    } t_state;

    t_state                       r_state;
    t_phase                       r_phase;
    logic [AXIS_BITS-1:0]         r_a, r_b;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic                         r_solid;
    logic [ID_W-1:0]              r_id;
    logic [SQ_W-1:0]              r_a2, r_b2;
    logic [WX_W-1:0]              r_x;
    logic signed [WALK_W-1:0]     r_y, r_top;
    logic signed [DEC_W-1:0]      r_dec;
    logic signed [PROD_W-1:0]     r_p1;
    t_emit_kind                   r_kind;
    logic                         r_done;
    logic [WX_W-1:0]              r_xo;
    logic signed [WALK_W-1:0]     r_yo;

    logic signed [OPB_W-1:0] x_b, y_b, a_b, b_b;
    logic signed [OPB_W-1:0] one_m_2a, one_m_2b, one_m_x, one_m_y, x4p6, y4p6;
    logic signed [DEC_W-1:0] prod_d;
    logic [DEC_W-1:0]        a2x2, b2x2;

    always_comb begin
        x_b      = OPB_W'(r_x);
        y_b      = OPB_W'(r_y);
        a_b      = OPB_W'(r_a);
        b_b      = OPB_W'(r_b);
        one_m_2a = OPB_W'(1) - (a_b <<< 1);
        one_m_2b = OPB_W'(1) - (b_b <<< 1);
        one_m_x  = OPB_W'(1) - x_b;
        one_m_y  = OPB_W'(1) - y_b;
        x4p6     = (x_b <<< 2) + OPB_W'(6);
        y4p6     = (y_b <<< 2) + OPB_W'(6);
        prod_d   = DEC_W'(i_prod);
        a2x2     = DEC_W'(r_a2) << 1;
        b2x2     = DEC_W'(r_b2) << 1;
    end

    // operand select for the shared multiplier
    always_comb begin
        o_mul_op = '0;
        unique case (r_state)
            S_SQA: begin
                o_mul_op.a = SQ_W'(r_a);
                o_mul_op.b = a_b;
            end
            S_SQB: begin
                o_mul_op.a = SQ_W'(r_b);
                o_mul_op.b = b_b;
            end
            S_DEC0: begin
                o_mul_op.a = r_a2;
                o_mul_op.b = one_m_2b;
            end
            S_T1, S_S2: begin
                o_mul_op.a = r_b2;
                o_mul_op.b = x_b;
            end
            S_T2, S_S1: begin
                o_mul_op.a = r_a2;
                o_mul_op.b = y_b;
            end
            S_TUPA: begin
                o_mul_op.a = r_a2;
                o_mul_op.b = one_m_y;
            end
            S_TACCA, S_TUPB: begin
                o_mul_op.a = r_b2;
                o_mul_op.b = x4p6;
            end
            S_SET: begin
                o_mul_op.a = r_b2;
                o_mul_op.b = one_m_2a;
            end
            S_SUPC: begin
                o_mul_op.a = r_b2;
                o_mul_op.b = one_m_x;
            end
            S_SACCC, S_SUPD: begin
                o_mul_op.a = r_a2;
                o_mul_op.b = y4p6;
            end
            default: o_mul_op = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        if (i_req.action == ACT_START) begin
                            r_a     <= i_req.semi_x;
                            r_b     <= i_req.semi_y;
                            r_cx    <= i_req.centre_x;
                            r_cy    <= i_req.centre_y;
                            r_solid <= i_req.solid;
                            r_id    <= i_req.shape_id;
                            r_x     <= '0;
                            r_y     <= WALK_W'(i_req.semi_y);
                            r_top   <= '0;
                            r_state <= S_SQA;
                        end else begin
                            unique case (r_phase)
                                PH_TOPBOT: r_state <= S_T1;
                                PH_SIDES:  r_state <= S_S1;
                                default: begin
                                    r_kind  <= EK_NONE;
                                    r_done  <= 1'b1;
                                    r_state <= S_EMIT;
                                end
                            endcase
                        end
                    end
                end
                S_SQA: r_state <= S_SQB;
                S_SQB: begin
                    r_a2    <= i_prod[SQ_W-1:0];
                    r_state <= S_DEC0;
                end
                S_DEC0: begin
                    r_b2    <= i_prod[SQ_W-1:0];
                    r_state <= S_DEC1;
                end
                S_DEC1: begin
                    r_dec   <= b2x2 + prod_d;
                    r_kind  <= EK_NONE;
                    // both axes zero: nothing to walk
                    if (r_a == '0 && r_b == '0) begin
                        r_phase <= PH_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_phase <= PH_TOPBOT;
                        r_done  <= 1'b0;
                    end
                    r_state <= S_EMIT;
                end
                // top and bottom region
                S_T1: r_state <= S_T2;
                S_T2: begin
                    r_p1    <= i_prod;
                    r_state <= S_TCMP;
                end
                S_TCMP: begin
                    r_done <= 1'b0;
                    if (r_p1 <= i_prod) begin
                        // points only when the decision is not negative
                        r_kind  <= r_dec[DEC_W-1] ? EK_NONE : EK_FOUR;
                        r_xo    <= r_x;
                        r_yo    <= r_y;
                        r_state <= r_dec[DEC_W-1] ? S_TUPB : S_TUPA;
                    end else begin
                        r_top   <= r_y;
                        r_kind  <= EK_PAIR;
                        r_xo    <= WX_W'(r_a);
                        r_yo    <= '0;
                        r_x     <= WX_W'(r_a);
                        r_y     <= WALK_W'(1);
                        r_state <= S_SET;
                    end
                end
                S_TUPA: r_state <= S_TACCA;
                S_TACCA: begin
                    r_dec   <= r_dec + (prod_d <<< 2);
                    r_y     <= r_y - WALK_W'(1);
                    r_state <= S_TACCB;
                end
                S_TUPB: r_state <= S_TACCB;
                S_TACCB: begin
                    r_dec   <= r_dec + prod_d;
                    r_x     <= r_x + WX_W'(1);
                    r_state <= S_EMIT;
                end
                S_SET: r_state <= S_SET2;
                S_SET2: begin
                    r_dec   <= a2x2 + prod_d;
                    r_phase <= PH_SIDES;
                    r_state <= S_EMIT;
                end
                // left and right region
                S_S1: r_state <= S_S2;
                S_S2: begin
                    r_p1    <= i_prod;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if ((r_p1 < i_prod) && (r_y <= r_top)) begin
                        r_kind  <= EK_FOUR;
                        r_done  <= 1'b0;
                        r_xo    <= r_x;
                        r_yo    <= r_y;
                        r_state <= r_dec[DEC_W-1] ? S_SUPD : S_SUPC;
                    end else begin
                        r_kind  <= EK_NONE;
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                        r_state <= S_EMIT;
                    end
                end
                S_SUPC: r_state <= S_SACCC;
                S_SACCC: begin
                    r_dec   <= r_dec + (prod_d <<< 2);
                    r_x     <= r_x - WX_W'(1);
                    r_state <= S_SACCD;
                end
                S_SUPD: r_state <= S_SACCD;
                S_SACCD: begin
                    r_dec   <= r_dec + prod_d;
                    r_y     <= r_y + WALK_W'(1);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_cmd_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_cmd_valid = (r_state == S_EMIT);

    always_comb begin
        o_cmd       = '0;
        o_cmd.kind  = r_kind;
        o_cmd.done  = r_done;
        o_cmd.x_off = r_xo;
        o_cmd.y_off = r_yo;
        o_cmd.cx    = r_cx;
        o_cmd.cy    = r_cy;
        o_cmd.solid = r_solid;
        o_cmd.id    = r_id;
    end

    `ESP_ASSERT_IMPL(a_tcmp_in_topbot, (r_state == S_TCMP), (r_phase == PH_TOPBOT))
    `ESP_ASSERT_IMPL(a_scmp_in_sides, (r_state == S_SCMP), (r_phase == PH_SIDES))
    `ESP_ASSERT_NEXT(a_accept_goes_busy, (i_req_valid && o_req_ready), !o_req_ready)

endmodule

// ===== rtl/core/ellipse_span_switch_points_top.sv =====
// top level of the midpoint ellipse span switch point walker
//
//  channel   direction  handshake                   payload
//  request   in         i_req_valid / o_req_ready   i_req (start or step)
//  result    out        o_res_valid / i_res_ready   o_res (one switch point)
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_data (screen height)
//
// a step request is done once the emitter takes its command (no walk in the idle phase):
//   the walk makes two to four products one after another on the single 25x16 multiplier
// a start request makes two squares and the initial decision
// results leave one per cycle from the output register while the result side is ready;
//   a request's points reach the emitter once the previous last result is in that register
// synchronous active-low reset; screen height resets to 480, walk returns to idle
// a stalled result side holds the emitter, which in turn holds the sequencer
`timescale 1ns / 1ps
module ellipse_span_switch_points_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  esp_pkg::t_in_item             i_req,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output esp_pkg::t_out_item            o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [esp_pkg::HEIGHT_W-1:0]  i_cfg_data
);
    import esp_pkg::*;

    logic [HEIGHT_W-1:0]      r_height;
    logic [HEIGHT_W-1:0]      lim;
    t_mul_op                  mul_op;
    logic signed [PROD_W-1:0] prod;
    logic                     cmd_valid;
    logic                     cmd_ready;
    t_emit_cmd                cmd;

    // height register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_W'(HEIGHT_RST);
        end else if (i_cfg_valid) begin
            r_height <= i_cfg_data;
        end
    end

    // heights above the largest scanline count act as that count
    assign lim = (r_height > HEIGHT_W'(LIM_MAX)) ? HEIGHT_W'(LIM_MAX) : r_height;

    // sequencer: walk state, region tests and decision updates
    esp_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_mul_op    (mul_op),
        .i_prod      (prod),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // the one multiplier every product goes through
    esp_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    // mirrors the offsets into up to four points, clips rows, clamps columns
    esp_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lim       (lim),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

endmodule
